>>> sv/ctf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared types and constants for the column tracer ridge follower.
// ----------------------------------------------------------------------------
package ctf_pkg;

    // register map, index = paddr / 4
    localparam logic [2:0] REG_HEIGHT   = 3'd0;
    localparam logic [2:0] REG_DISTANCE = 3'd1;
    localparam logic [2:0] REG_SPACING  = 3'd2;
    localparam logic [2:0] REG_COUNT    = 3'd3;
    localparam logic [2:0] REG_MODE     = 3'd4;

    // register reset values
    localparam logic [10:0] CFG_RST_HEIGHT   = 11'd1024;
    localparam logic [9:0]  CFG_RST_DISTANCE = 10'd8;
    localparam logic [10:0] CFG_RST_SPACING  = 11'd16;
    localparam logic [6:0]  CFG_RST_COUNT    = 7'd64;
    localparam logic        CFG_RST_MODE     = 1'b0;

    localparam int unsigned ROW_MAX = 1023;

    typedef struct packed {
        logic [10:0] height;
        logic [9:0]  distance;
        logic [10:0] spacing;
        logic [6:0]  count;
        logic        mode;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic pix_wr;     // store accepted pixel, advance row count
        logic idx_clr;
        logic idx_inc;
        logic place_wr;   // write initial layout row for tracer idx
        logic place_rst;  // layout from reset register values
        logic top_rd;     // tracer row ready: fetch upper pixel
        logic bot_rd;     // fetch lower pixel, hold upper
        logic calc;       // decide move, write back, load result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic col_end;    // current pixel closes the column
        logic idx_last;   // idx is the last active tracer
        logic out_free;   // result register can take a beat
    } t_sts;

endpackage

>>> sv/ctf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ctf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/ctf_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_regs
// APB register file for the tracer configuration.
// ----------------------------------------------------------------------------
module ctf_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output ctf_pkg::t_cfg      o_cfg,
    output logic               o_cfg_wr
);
    import ctf_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.height   <= CFG_RST_HEIGHT;
            r_cfg.distance <= CFG_RST_DISTANCE;
            r_cfg.spacing  <= CFG_RST_SPACING;
            r_cfg.count    <= CFG_RST_COUNT;
            r_cfg.mode     <= CFG_RST_MODE;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HEIGHT:   r_cfg.height   <= pwdata[10:0];
                REG_DISTANCE: r_cfg.distance <= pwdata[9:0];
                REG_SPACING:  r_cfg.spacing  <= pwdata[10:0];
                REG_COUNT:    r_cfg.count    <= pwdata[6:0];
                REG_MODE:     r_cfg.mode     <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HEIGHT:   prdata = {21'd0, r_cfg.height};
            REG_DISTANCE: prdata = {22'd0, r_cfg.distance};
            REG_SPACING:  prdata = {21'd0, r_cfg.spacing};
            REG_COUNT:    prdata = {25'd0, r_cfg.count};
            REG_MODE:     prdata = {31'd0, r_cfg.mode};
            default:      prdata = 32'd0;
        endcase
    end

    assign o_cfg    = r_cfg;
    assign o_cfg_wr = wr_en;

endmodule

>>> sv/ctf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_datapath
// Column store, tracer row store, layout and step logic, result register.
// ----------------------------------------------------------------------------
module ctf_datapath #(
    parameter int MAX_HEIGHT  = 1024,
    parameter int MAX_TRACERS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctf_pkg::t_cfg      i_cfg,
    input  ctf_pkg::t_cmd      i_cmd,
    output ctf_pkg::t_sts      o_sts,
    input  logic [7:0]         i_pixel,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [5:0]         o_tracer_index,
    output logic [9:0]         o_tracer_row,
    output logic               o_last
);
    import ctf_pkg::*;

    localparam int AW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = (HW > 11) ? HW : 11;
    localparam int SD = 2 * (2 ** AW);
    localparam int TW = $clog2(MAX_TRACERS);
    localparam int PW = TW + 11;

    // counters
    logic [AW-1:0] r_rc;
    logic          r_bank;
    logic [TW-1:0] r_idx;

    // pass registers
    logic [9:0] r_row;
    logic [7:0] r_top;

    // result register
    logic          r_out_valid;
    logic [TW-1:0] r_out_idx;
    logic [9:0]    r_out_row;
    logic          r_out_last;

    // effective configuration
    logic [10:0]   raw_h;
    logic [10:0]   raw_s;
    logic [6:0]    raw_n;
    logic [XW-1:0] h_x;
    logic [XW-1:0] eff_h;
    logic [XW-1:0] hm1;
    logic [XW-1:0] hm2;
    logic [9:0]    upper;
    logic [6:0]    eff_n;
    logic [6:0]    nm1_w;
    logic [TW-1:0] nm1;

    // layout
    logic [TW-1:0] lay_k;
    logic [TW-1:0] lay_km1;
    logic [PW-1:0] lay_p;
    logic [9:0]    lay_row;

    // addressing
    logic [HW-1:0] rc_inc;
    logic [9:0]    trk_rdata;
    logic [7:0]    st_rdata;
    logic [9:0]    top_sub;
    logic [XW-1:0] top_x;
    logic [AW-1:0] top_row;
    logic [10:0]   bot_sum;
    logic [XW-1:0] bot_x;
    logic [AW-1:0] bot_row;
    logic [AW:0]   st_raddr;
    logic [AW:0]   st_waddr;

    // step
    logic       go_down;
    logic       go_up;
    logic [9:0] new_row;

    logic          trk_we;
    logic [9:0]    trk_wdata;
    logic          out_free;

    // reset sweep uses the register reset values, so a write during it cannot leak in
    assign raw_h = i_cmd.place_rst ? CFG_RST_HEIGHT  : i_cfg.height;
    assign raw_s = i_cmd.place_rst ? CFG_RST_SPACING : i_cfg.spacing;
    assign raw_n = i_cmd.place_rst ? CFG_RST_COUNT   : i_cfg.count;

    assign h_x = XW'(raw_h);
    always_comb begin
        if (h_x < XW'(3)) begin
            eff_h = XW'(3);
        end else if (h_x > XW'(MAX_HEIGHT)) begin
            eff_h = XW'(MAX_HEIGHT);
        end else begin
            eff_h = h_x;
        end
    end
    assign hm1   = eff_h - XW'(1);
    assign hm2   = eff_h - XW'(2);
    assign upper = (hm2 > XW'(ROW_MAX)) ? 10'(ROW_MAX) : hm2[9:0];

    always_comb begin
        if (raw_n < 7'd3) begin
            eff_n = 7'd3;
        end else if (raw_n > 7'(MAX_TRACERS)) begin
            eff_n = 7'(MAX_TRACERS);
        end else begin
            eff_n = raw_n;
        end
    end
    assign nm1_w = eff_n - 7'd1;
    assign nm1   = nm1_w[TW-1:0];

    // end slots copy their inner neighbours
    always_comb begin
        if (r_idx == '0) begin
            lay_k = TW'(1);
        end else if (r_idx == nm1) begin
            lay_k = nm1 - TW'(1);
        end else begin
            lay_k = r_idx;
        end
    end
    assign lay_km1 = lay_k - TW'(1);
    assign lay_p   = PW'(lay_km1) * PW'(raw_s);
    assign lay_row = (lay_p > PW'(upper)) ? upper : lay_p[9:0];

    // column store
    assign rc_inc   = HW'(r_rc) + HW'(1);
    assign st_waddr = {r_bank, r_rc};

    assign top_sub = (trk_rdata > i_cfg.distance) ? (trk_rdata - i_cfg.distance) : 10'd0;
    assign top_x   = (XW'(top_sub) > hm1) ? hm1 : XW'(top_sub);
    assign top_row = top_x[AW-1:0];

    assign bot_sum = 11'(r_row) + 11'(i_cfg.distance);
    assign bot_x   = (XW'(bot_sum) < eff_h) ? XW'(bot_sum) : hm1;
    assign bot_row = bot_x[AW-1:0];

    // the pass reads the bank that was just closed
    assign st_raddr = i_cmd.top_rd ? {~r_bank, top_row} : {~r_bank, bot_row};

    ctf_ram #(
        .WIDTH (8),
        .DEPTH (SD)
    ) u_col_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pix_wr),
        .i_waddr (st_waddr),
        .i_wdata (i_pixel),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // step decision
    always_comb begin
        go_down = i_cfg.mode ? (r_top < st_rdata) : (r_top > st_rdata);
        go_up   = i_cfg.mode ? (r_top > st_rdata) : (r_top < st_rdata);
        if (go_down && (r_row < upper)) begin
            new_row = r_row + 10'd1;
        end else if (go_up && (r_row != 10'd0)) begin
            new_row = r_row - 10'd1;
        end else begin
            new_row = r_row;
        end
    end

    assign trk_we    = i_cmd.place_wr | i_cmd.calc;
    assign trk_wdata = i_cmd.place_wr ? lay_row : new_row;

    ctf_ram #(
        .WIDTH (10),
        .DEPTH (MAX_TRACERS)
    ) u_trk_store (
        .i_clk   (i_clk),
        .i_we    (trk_we),
        .i_waddr (r_idx),
        .i_wdata (trk_wdata),
        .i_raddr (r_idx),
        .o_rdata (trk_rdata)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc        <= '0;
            r_bank      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.pix_wr) begin
                if (XW'(rc_inc) >= eff_h) begin
                    r_rc   <= '0;
                    r_bank <= ~r_bank;
                end else begin
                    r_rc <= rc_inc[AW-1:0];
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + TW'(1);
            end
            if (i_cmd.calc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.top_rd) begin
            r_row <= trk_rdata;
        end
        if (i_cmd.bot_rd) begin
            r_top <= st_rdata;
        end
        if (i_cmd.calc) begin
            r_out_idx  <= r_idx;
            r_out_row  <= new_row;
            r_out_last <= (r_idx == nm1);
        end
    end

    assign o_sts.col_end  = (XW'(rc_inc) >= eff_h);
    assign o_sts.idx_last = (r_idx == nm1);
    assign o_sts.out_free = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_tracer_index = 6'(r_out_idx);
    assign o_tracer_row   = r_out_row;
    assign o_last         = r_out_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.calc |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pix_wr && o_sts.col_end) |=> (r_rc == '0))
        else $error("row count did not restart at column end");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trk_we |-> (r_idx <= nm1))
        else $error("tracer write beyond active count");

endmodule

>>> sv/ctf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_ctrl
// Sequencer: reset layout sweep, pixel intake, re-layout, tracer pass.
// ----------------------------------------------------------------------------
module ctf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_first_column,
    input  logic               i_cfg_wr,
    input  ctf_pkg::t_sts      i_sts,
    output ctf_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);
    import ctf_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PLACE,
        S_TRD,
        S_TTOP,
        S_TBOT,
        S_TCALC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_placed;   // layout already written for the current registers
    logic   n_placed;
    logic   r_pend;     // pass owed after the layout sweep
    logic   n_pend;
    logic   r_in_stall;
    t_cmd   cmd;

    always_comb begin
        cmd      = '0;
        n_state  = r_state;
        n_placed = r_placed;
        n_pend   = r_pend;
        case (r_state)
            S_INIT: begin
                cmd.place_wr  = 1'b1;
                cmd.place_rst = 1'b1;
                if (i_sts.idx_last) begin
                    cmd.idx_clr = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.pix_wr = 1'b1;
                    if (i_first_column && !r_placed) begin
                        n_state = S_PLACE;
                        n_pend  = i_sts.col_end;
                    end else if (i_sts.col_end) begin
                        n_state = S_TRD;
                    end
                end
            end
            S_PLACE: begin
                cmd.place_wr = 1'b1;
                if (i_sts.idx_last) begin
                    cmd.idx_clr = 1'b1;
                    n_placed    = 1'b1;
                    n_state     = r_pend ? S_TRD : S_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_TRD: begin
                n_state = S_TTOP;
            end
            S_TTOP: begin
                cmd.top_rd = 1'b1;
                n_state    = S_TBOT;
            end
            S_TBOT: begin
                cmd.bot_rd = 1'b1;
                n_state    = S_TCALC;
            end
            S_TCALC: begin
                if (i_sts.out_free) begin
                    cmd.calc = 1'b1;
                    if (i_sts.idx_last) begin
                        cmd.idx_clr = 1'b1;
                        n_placed    = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        n_state     = S_TRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_wr) begin
            n_placed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_placed   <= 1'b0;
            r_pend     <= 1'b0;
            r_in_stall <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_placed   <= n_placed;
            r_pend     <= n_pend;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = r_in_stall;

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_stall |-> (r_state == S_IDLE))
        else $error("input open outside idle");

    a_pass_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TCALC && i_sts.out_free && i_sts.idx_last)
            |=> (r_state == S_IDLE && !r_placed))
        else $error("pass end did not return to idle");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.pix_wr, cmd.place_wr, cmd.top_rd, cmd.bot_rd, cmd.calc}))
        else $error("conflicting datapath commands");

endmodule

>>> sv/column_tracer_ridge_follower_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_tracer_ridge_follower_core
// Follows ridges or valleys across a column-streamed image with a row of
// tracers, one step per tracer per column.
// ----------------------------------------------------------------------------
// Pixels within a column: one beat per cycle, no result, input open next cycle.
// Column end: each active tracer gets a row read, upper pixel, lower pixel
//   and decide step with the input stalled; the decide step waits while the
//   result side stalls.
// First-column pixel after a register write or a pass: tracer layout sweep.
// Reset: synchronous; then a sweep over the reset tracer count writes the
//   default layout, input stalled. Register writes are taken throughout.
module column_tracer_ridge_follower_core #(
    parameter int MAX_HEIGHT  = 1024,
    parameter int MAX_TRACERS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel beats
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_pixel,
    input  logic        i_first_column,
    // tracer results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_tracer_index,
    output logic [9:0]  o_tracer_row,
    output logic        o_last
);
    import ctf_pkg::*;

    t_cfg cfg;
    logic cfg_wr;
    t_cmd cmd;
    t_sts sts;

    // Register file. A write also invalidates the cached layout, so the next
    // first-column pixel sweeps the tracers again with the new values.
    ctf_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_cfg_wr (cfg_wr)
    );

    // Sequencer. Only the idle state opens the input; every first-column
    // pixel after a pass or register write starts one layout sweep, repeated
    // ones are skipped as they would write the same rows.
    ctf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_first_column (i_first_column),
        .i_cfg_wr       (cfg_wr),
        .i_sts          (sts),
        .o_cmd          (cmd),
        .o_in_stall     (o_in_stall)
    );

    // Datapath: two-bank column store (pixels go to one bank, the pass reads
    // the bank just closed), tracer row RAM, and the result register.
    ctf_datapath #(
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_TRACERS (MAX_TRACERS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_pixel        (i_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_tracer_index (o_tracer_index),
        .o_tracer_row   (o_tracer_row),
        .o_last         (o_last)
    );

endmodule
